// ===== hdl/ciaf_pkg.sv =====
package ciaf_pkg;

  typedef enum logic [4:0] {
    CMD_ADD  = 5'd0,
    CMD_ADDQ = 5'd1,
    CMD_ADDX = 5'd2,
    CMD_ADDA = 5'd3,
    CMD_SUB  = 5'd4,
    CMD_SUBQ = 5'd5,
    CMD_SUBA = 5'd6,
    CMD_CMP  = 5'd7,
    CMD_CMPA = 5'd8,
    CMD_NEG  = 5'd9,
    CMD_CLR  = 5'd10,
    CMD_EXT  = 5'd11,
    CMD_MULU = 5'd12,
    CMD_MULS = 5'd13,
    CMD_DIVU = 5'd14,
    CMD_DIVS = 5'd15,
    CMD_TAS  = 5'd16
  } cmd_t;

  typedef enum logic [1:0] {
    SZ_BYTE = 2'd0,
    SZ_WORD = 2'd1,
    SZ_LONG = 2'd2,
    SZ_LONG3 = 2'd3
  } size_code_t;

  // Operation class chosen at the front end
  typedef enum logic [2:0] {
    CL_NOP,
    CL_SIMPLE,
    CL_MUL,
    CL_DIV
  } op_class_t;

  typedef struct packed {
    logic [4:0]  command;
    logic [1:0]  size_code;
    logic [31:0] source_value;
    logic [31:0] dest_value;
    op_class_t   op_class;
  } work_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic        write_back;
    logic [4:0]  flags;
    logic        divide_fault;
  } result_t;

  localparam int QueueDepth = 2;
  localparam int QueuePtrW = 1;
  localparam int DivSteps = 32;
  localparam logic [31:0] HiWordMask = 32'hFFFF0000;
  localparam logic [31:0] LoWordMask = 32'h0000FFFF;

  localparam int FX = 4;
  localparam int FN = 3;
  localparam int FZ = 2;
  localparam int FV = 1;
  localparam int FC = 0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  function automatic logic [31:0] size_mask(input logic [1:0] sz);
    logic [31:0] m;
    unique case (sz)
      SZ_BYTE: m = 32'h0000_00FF;
      SZ_WORD: m = LoWordMask;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [31:0] sext16(input logic [31:0] v);
    return {{16{v[15]}}, v[15:0]};
  endfunction

endpackage

// ===== hdl/ciaf_front.sv =====
module ciaf_front import ciaf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [4:0]  command,
  input  logic [1:0]  size_code,
  input  logic [31:0] source_value,
  input  logic [31:0] dest_value,
  output logic        q_valid,
  output work_t       q_data,
  input  logic        q_take
);

  work_t             mem [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr, rd_ptr;
  logic [QueuePtrW:0]   count;
  op_class_t         cls;
  logic              do_push, do_pop;

  always_comb begin
    priority if (command == CMD_MULU || command == CMD_MULS) begin
      cls = CL_MUL;
    end else if (command == CMD_DIVU || command == CMD_DIVS) begin
      cls = CL_DIV;
    end else if (command <= CMD_TAS) begin
      cls = CL_SIMPLE;
    end else begin
      cls = CL_NOP;
    end
  end

  assign full    = (count == (QueuePtrW+1)'(QueueDepth));
  assign q_valid = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = q_take && q_valid;
  assign q_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= '{command, size_code, source_value, dest_value, cls};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QueuePtrW+1)'(do_push) - (QueuePtrW+1)'(do_pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count <= (QueuePtrW+1)'(QueueDepth)) else $error("queue overfilled");
  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    full && !do_pop |=> $stable(wr_ptr)) else $error("write while full");
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    !q_valid |=> $stable(rd_ptr)) else $error("read while empty");
`endif

endmodule

// ===== hdl/ciaf_back.sv =====
module ciaf_back import ciaf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  input  work_t   q_data,
  output logic    q_take,
  output logic    res_valid,
  output result_t res_data,
  input  logic    res_take
);

  state_t      state, state_next;
  work_t       w;
  logic [4:0]  flags;
  result_t     out_reg;
  logic        out_full;

  // multiplier operands and product register
  logic [15:0] mul_a, mul_b;
  logic [31:0] prod;
  logic        mul_neg;

  // restoring divider
  logic [31:0] div_rem_q;
  logic [16:0] div_part;
  logic [15:0] div_ub;
  logic [5:0]  div_cnt;
  logic        qneg, rneg;
  logic [17:0] trial;

  logic        start, finish;
  result_t     simple_res, mul_res, div_res, fin_res;

  assign q_take = (state == ST_IDLE) && q_valid;
  assign start  = q_take;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (q_valid) begin
        if (q_data.op_class == CL_MUL) state_next = ST_MUL;
        else if (q_data.op_class == CL_DIV && q_data.source_value[15:0] != '0)
          state_next = ST_DIV;
        else state_next = ST_DONE;
      end
      ST_MUL: state_next = ST_DONE;
      ST_DIV: if (div_cnt == 6'(DivSteps)) state_next = ST_DONE;
      ST_DONE: if (!out_full || res_take) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign finish = (state == ST_DONE) && (!out_full || res_take);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // latch item on take
  always_ff @(posedge clk) begin
    if (start) begin
      w       <= q_data;
      mul_a   <= (q_data.command == CMD_MULS && q_data.source_value[15])
                 ? 16'(-q_data.source_value[15:0]) : q_data.source_value[15:0];
      mul_b   <= (q_data.command == CMD_MULS && q_data.dest_value[15])
                 ? 16'(-q_data.dest_value[15:0]) : q_data.dest_value[15:0];
      mul_neg <= (q_data.command == CMD_MULS)
                 && (q_data.source_value[15] ^ q_data.dest_value[15]);
    end
  end

  // multiply: one 16x16 product, sign fix applied in the done stage
  always_ff @(posedge clk) begin
    if (state == ST_MUL) prod <= 32'(mul_a) * 32'(mul_b);
  end

  assign trial   = {1'b0, div_part} * 18'd2 + 18'(div_rem_q[31]) - 18'(div_ub);

  always_ff @(posedge clk) begin
    if (start) begin
      div_cnt  <= '0;
      div_part <= '0;
      if (q_data.command == CMD_DIVS) begin
        rneg      <= q_data.dest_value[31];
        div_rem_q <= q_data.dest_value[31] ? -q_data.dest_value : q_data.dest_value;
        div_ub    <= q_data.source_value[15] ? 16'(-q_data.source_value[15:0])
                                             : q_data.source_value[15:0];
        qneg      <= q_data.dest_value[31] ^ q_data.source_value[15];
      end else begin
        rneg      <= 1'b0;
        qneg      <= 1'b0;
        div_rem_q <= q_data.dest_value;
        div_ub    <= q_data.source_value[15:0];
      end
    end else if (state == ST_DIV && div_cnt != 6'(DivSteps)) begin
      div_cnt <= div_cnt + 1'b1;
      if (!trial[17]) begin
        div_part  <= trial[16:0];
        div_rem_q <= {div_rem_q[30:0], 1'b1};
      end else begin
        div_part  <= {div_part[15:0], div_rem_q[31]};
        div_rem_q <= {div_rem_q[30:0], 1'b0};
      end
    end
  end

  // simple ops
  always_comb begin
    logic [31:0] m, msb, am, bm, q, r, s32, dres;
    logic [32:0] sum;
    logic [4:0]  f;
    logic        x;
    m   = size_mask(w.size_code);
    msb = m ^ (m >> 1);
    x   = flags[FX];
    f   = flags;
    q   = w.source_value;
    r   = '0;
    sum = '0;
    am  = '0;
    bm  = '0;
    s32 = (w.size_code[1]) ? w.source_value : sext16(w.source_value);
    dres = w.dest_value;
    simple_res = '{w.dest_value, 1'b0, flags, 1'b0};
    if (w.command == CMD_ADDQ || w.command == CMD_SUBQ) begin
      q = {29'd0, w.source_value[2:0]};
      if (q == '0) q = 32'd8;
    end
    if (w.op_class == CL_SIMPLE) begin
      unique case (w.command)
        CMD_ADD, CMD_ADDQ, CMD_ADDX: begin
          am  = w.dest_value & m;
          bm  = q & m;
          sum = {1'b0, am} + {1'b0, bm}
                + 33'(w.command == CMD_ADDX && x);
          r   = sum[31:0] & m;
          f[FC] = (({1'b0, m} ^ 33'h1_FFFF_FFFF) & sum) != '0;
          f[FV] = (((w.dest_value ^ r) & (q ^ r)) & msb) != '0;
          f[FN] = (r & msb) != '0;
          if (w.command == CMD_ADDX) f[FZ] = ((r & m) == '0) ? flags[FZ] : 1'b0;
          else f[FZ] = ((r & m) == '0);
          f[FX] = f[FC];
          simple_res = '{(w.dest_value & ~m) | r, 1'b1, f, 1'b0};
        end
        CMD_SUB, CMD_SUBQ, CMD_NEG, CMD_CMP, CMD_CMPA: begin
          if (w.command == CMD_NEG) begin
            am = '0; bm = w.dest_value;
          end else if (w.command == CMD_CMPA) begin
            am = w.dest_value; bm = s32; m = '1; msb = 32'h8000_0000;
          end else begin
            am = w.dest_value; bm = q;
          end
          r     = ((am & m) - (bm & m)) & m;
          f[FC] = (bm & m) > (am & m);
          f[FV] = (((am ^ bm) & (am ^ r)) & msb) != '0;
          f[FN] = (r & msb) != '0;
          f[FZ] = (r == '0);
          if (w.command == CMD_CMP || w.command == CMD_CMPA) begin
            f[FX] = x;
            simple_res = '{w.dest_value, 1'b0, f, 1'b0};
          end else begin
            f[FX] = f[FC];
            simple_res = '{(w.dest_value & ~m) | r, 1'b1, f, 1'b0};
          end
        end
        CMD_ADDA, CMD_SUBA: begin
          dres = (w.command == CMD_ADDA) ? w.dest_value + s32 : w.dest_value - s32;
          simple_res = '{dres, 1'b1, flags, 1'b0};
        end
        CMD_CLR: simple_res = '{w.dest_value & ~m, 1'b1, {x, 4'b0100}, 1'b0};
        CMD_EXT: begin
          if (w.size_code[1]) begin
            r = sext16(w.dest_value);
            simple_res = '{r, 1'b1, {x, r[31], r == '0, 2'b00}, 1'b0};
          end else begin
            r = {16'd0, {8{w.dest_value[7]}}, w.dest_value[7:0]};
            simple_res = '{(w.dest_value & HiWordMask) | r, 1'b1,
                           {x, r[15], r[15:0] == '0, 2'b00}, 1'b0};
          end
        end
        CMD_TAS: simple_res = '{w.dest_value | 32'h80, 1'b0,
                   {x, w.dest_value[7], w.dest_value[7:0] == '0, 2'b00}, 1'b0};
        default: simple_res = '{w.dest_value, 1'b0, flags, 1'b0};
      endcase
    end
  end

  always_comb begin
    logic [31:0] p;
    p = mul_neg ? -prod : prod;
    mul_res = '{p, 1'b1, {flags[FX], p[31], p == '0, 2'b00}, 1'b0};
  end

  always_comb begin
    logic [31:0] qq, rr;
    logic [15:0] qo, ro;
    logic        ovf;
    qq  = div_rem_q;
    rr  = {15'd0, div_part};
    ovf = (w.command == CMD_DIVS) ? (qneg ? (qq > 32'h8000) : (qq > 32'h7FFF))
                                  : (qq > LoWordMask);
    qo  = qneg ? 16'(-qq) : qq[15:0];
    ro  = rneg ? 16'(-rr) : rr[15:0];
    if (w.source_value[15:0] == '0) begin
      div_res = '{w.dest_value, 1'b0, flags, 1'b1};
    end else if (ovf) begin
      div_res = '{w.dest_value, 1'b0, {flags[4:2], 2'b10}, 1'b0};
    end else begin
      div_res = '{{ro, qo}, 1'b1, {flags[FX], qo[15], qo == '0, 2'b00}, 1'b0};
    end
  end

  always_comb begin
    unique case (w.op_class)
      CL_MUL:  fin_res = mul_res;
      CL_DIV:  fin_res = div_res;
      default: fin_res = simple_res;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags    <= '0;
      out_full <= 1'b0;
    end else begin
      if (finish) begin
        flags    <= fin_res.flags;
        out_full <= 1'b1;
      end else if (res_take) begin
        out_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) out_reg <= fin_res;
  end

  assign res_valid = out_full;
  assign res_data  = out_reg;

`ifndef SYNTHESIS
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    q_take |-> state == ST_IDLE) else $error("take outside idle");
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> div_cnt <= 6'(DivSteps)) else $error("divide overran");
  a_fin_full: assert property (@(posedge clk) disable iff (rst)
    finish |=> out_full) else $error("result lost");
`endif

endmodule

// ===== hdl/cisc_integer_alu_with_flags.sv =====
// Integer ALU with X N Z V C flags, queue-style ports on both sides. A front
// queue of two entries takes items and sorts them into simple, multiply, divide
// or no-op; the execute unit works on one item at a time and holds its result
// in a single output register until it is popped. With the execute unit idle
// and the output register free, simple ops, unknown commands and divides by
// zero go straight from the idle state to the done state, multiply passes
// through one 16x16 product stage and divide through a restoring divider
// retiring one quotient bit per cycle, 32 bits in all. The next item is taken
// the cycle after a result is loaded; an unpopped result holds the execute
// unit. Flags persist between items; reset clears them.
module cisc_integer_alu_with_flags import ciaf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [4:0]  command,
  input  logic [1:0]  size_code,
  input  logic [31:0] source_value,
  input  logic [31:0] dest_value,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] result_value,
  output logic        write_back,
  output logic        flag_extend,
  output logic        flag_negative,
  output logic        flag_zero,
  output logic        flag_overflow,
  output logic        flag_carry,
  output logic        divide_fault
);

  logic    q_valid, q_take, res_valid;
  work_t   q_data;
  result_t res_data;

  ciaf_front u_front (
    .clk, .rst, .push, .full, .command, .size_code, .source_value,
    .dest_value, .q_valid, .q_data, .q_take
  );

  ciaf_back u_back (
    .clk, .rst, .q_valid, .q_data, .q_take, .res_valid, .res_data,
    .res_take (pop && res_valid)
  );

  assign empty         = !res_valid;
  assign result_value  = res_data.result_value;
  assign write_back    = res_data.write_back;
  assign flag_extend   = res_data.flags[FX];
  assign flag_negative = res_data.flags[FN];
  assign flag_zero     = res_data.flags[FZ];
  assign flag_overflow = res_data.flags[FV];
  assign flag_carry    = res_data.flags[FC];
  assign divide_fault  = res_data.divide_fault;

endmodule
